FILE: sv/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Operation codes and the side-band record that travels with each transaction
// through the fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

   // Operation codes carried in req_type.
   localparam logic [3:0] OP_ADD      = 4'd0;
   localparam logic [3:0] OP_SUB      = 4'd1;
   localparam logic [3:0] OP_MUL      = 4'd2;
   localparam logic [3:0] OP_DIV      = 4'd3;
   localparam logic [3:0] OP_INC      = 4'd4;
   localparam logic [3:0] OP_DEC      = 4'd5;
   localparam logic [3:0] OP_CMP      = 4'd6;
   localparam logic [3:0] OP_MIN      = 4'd7;
   localparam logic [3:0] OP_MAX      = 4'd8;
   localparam logic [3:0] OP_TO_INT   = 4'd9;
   localparam logic [3:0] OP_FROM_INT = 4'd10;

   // Everything about a transaction except the divider's own working state.
   typedef struct packed {
      logic [31:0] base;      // result of the simple operations
      logic [63:0] prod;      // full signed product for multiply
      logic        is_mul;
      logic        is_div;
      logic        neg;       // quotient must be negated
      logic        lt;
      logic        eq;
      logic        gt;
      logic        dz;        // divide by zero
   } fpa_side_type;

endpackage

FILE: sv/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed 32-bit fixed-point ALU with FRAC_WIDTH fraction bits: add, subtract,
// multiply, divide, increment, decrement, compare, min, max and conversions.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports
//  request   in         req_valid, req_stall, req_type, req_operand_a/b
//  response  out        rsp_valid, rsp_stall, rsp_result_value, flags
//
//  One transaction is accepted per cycle unless a result is held up. Each
//  result passes the input register, the divider (one quotient bit a stage)
//  and the output register. Every operation takes the same path, so results
//  leave in request order. Reset clears all valid bits. A stalled response
//  freezes the whole pipeline and stalls the request side in the same cycle.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
   parameter int FRAC_WIDTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_type,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_is_less,
   output logic               rsp_is_equal,
   output logic               rsp_is_greater,
   output logic               rsp_divide_by_zero
);
   import fpa_pkg::*;

   localparam int QW = 32 + FRAC_WIDTH;

   logic               advance;
   logic               s1_valid_ff;
   logic [3:0]         s1_op_ff;
   logic signed [31:0] s1_a_ff;
   logic signed [31:0] s1_b_ff;
   fpa_side_type       s2_side_in;
   logic [QW-1:0]      s2_num_in;
   logic [31:0]        s2_den_in;
   logic [31:0]        mag_a;
   logic               dv_valid;
   fpa_side_type       dv_side;
   logic [QW-1:0]      dv_quo;
   logic [31:0]        res_in;
   logic               rsp_valid_ff;
   logic [31:0]        res_ff;
   logic               lt_ff;
   logic               eq_ff;
   logic               gt_ff;
   logic               dz_ff;

   // The pipeline moves unless a finished result is held up.
   assign advance   = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         s1_op_ff <= req_type;
         s1_a_ff  <= req_operand_a;
         s1_b_ff  <= req_operand_b;
      end
   end

   // Simple operations, flags, the product and divider set-up.
   assign mag_a = s1_a_ff[31] ? (32'd0 - s1_a_ff) : s1_a_ff;

   always_comb begin
      s2_side_in.prod   = 64'(64'(s1_a_ff) * 64'(s1_b_ff));
      s2_side_in.lt     = s1_a_ff < s1_b_ff;
      s2_side_in.eq     = s1_a_ff == s1_b_ff;
      s2_side_in.gt     = s1_a_ff > s1_b_ff;
      s2_side_in.is_mul = s1_op_ff == OP_MUL;
      s2_side_in.is_div = s1_op_ff == OP_DIV;
      s2_side_in.dz     = (s1_op_ff == OP_DIV) && (s1_b_ff == 32'sd0);
      s2_side_in.neg    = s1_a_ff[31] ^ s1_b_ff[31];
      unique case (s1_op_ff)
         OP_ADD:      s2_side_in.base = s1_a_ff + s1_b_ff;
         OP_SUB:      s2_side_in.base = s1_a_ff - s1_b_ff;
         OP_INC:      s2_side_in.base = s1_a_ff + 32'sd1;
         OP_DEC:      s2_side_in.base = s1_a_ff - 32'sd1;
         OP_MIN:      s2_side_in.base = s2_side_in.lt ? s1_a_ff : s1_b_ff;
         OP_MAX:      s2_side_in.base = s2_side_in.gt ? s1_a_ff : s1_b_ff;
         OP_TO_INT:   s2_side_in.base = s1_a_ff >>> FRAC_WIDTH;
         OP_FROM_INT: s2_side_in.base = s1_a_ff << FRAC_WIDTH;
         default:     s2_side_in.base = 32'd0;
      endcase
   end

   assign s2_num_in = {{(QW-32){1'b0}}, mag_a} << FRAC_WIDTH;
   assign s2_den_in = s1_b_ff[31] ? (32'd0 - s1_b_ff) : s1_b_ff;

   fpa_div #(
      .QW(QW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid_ff),
      .in_side   (s2_side_in),
      .in_num    (s2_num_in),
      .in_den    (s2_den_in),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_quo   (dv_quo)
   );

   // Final selection of the result.
   always_comb begin
      priority if (dv_side.is_mul) begin
         res_in = dv_side.prod[FRAC_WIDTH+31:FRAC_WIDTH];
      end else if (dv_side.is_div) begin
         if (dv_side.dz) begin
            res_in = 32'd0;
         end else if (dv_side.neg) begin
            res_in = 32'd0 - dv_quo[31:0];
         end else begin
            res_in = dv_quo[31:0];
         end
      end else begin
         res_in = dv_side.base;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
      if (advance) begin
         res_ff <= res_in;
         lt_ff  <= dv_side.lt;
         eq_ff  <= dv_side.eq;
         gt_ff  <= dv_side.gt;
         dz_ff  <= dv_side.dz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = res_ff;
   assign rsp_is_less        = lt_ff;
   assign rsp_is_equal       = eq_ff;
   assign rsp_is_greater     = gt_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule

FILE: sv/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// Fully pipelined unsigned restoring divider, one quotient bit per stage,
// which also carries the side-band record of each transaction.
// ----------------------------------------------------------------------------
module fpa_div #(
   parameter int QW = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  fpa_pkg::fpa_side_type in_side,
   input  logic [QW-1:0]        in_num,
   input  logic [31:0]          in_den,
   output logic                 out_valid,
   output fpa_pkg::fpa_side_type out_side,
   output logic [QW-1:0]        out_quo
);
   import fpa_pkg::*;

   logic         valid_ff [QW+1];
   fpa_side_type side_ff  [QW+1];
   logic [QW-1:0] nq_ff   [QW+1];
   logic [31:0]  rem_ff   [QW+1];
   logic [31:0]  den_ff   [QW+1];

   // Stage zero loads the magnitudes with a cleared remainder.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
      if (advance) begin
         side_ff[0] <= in_side;
         nq_ff[0]   <= in_num;
         rem_ff[0]  <= 32'd0;
         den_ff[0]  <= in_den;
      end
   end

   // Each later stage retires one quotient bit.
   for (genvar j = 1; j <= QW; j++) begin : g_step
      logic [32:0] trial;
      logic [33:0] diff;
      logic        take;

      assign trial = {rem_ff[j-1], nq_ff[j-1][QW-1]};
      assign diff  = {1'b0, trial} - {2'b00, den_ff[j-1]};
      assign take  = ~diff[33];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= valid_ff[j-1];
         end
         if (advance) begin
            side_ff[j] <= side_ff[j-1];
            den_ff[j]  <= den_ff[j-1];
            rem_ff[j]  <= take ? diff[31:0] : trial[31:0];
            nq_ff[j]   <= {nq_ff[j-1][QW-2:0], take};
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_side  = side_ff[QW];
   assign out_quo   = nq_ff[QW];

endmodule

FILE: tb/sv/tb_fixed_point_alu.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu
// Self-checking bench for the fixed-point ALU. A short table of directed
// transactions covers the operand extremes, every operation, divide by zero,
// overflow wrap and the unknown operation codes. Several hundred random
// transactions follow. Every result is compared with a local prediction, in
// request order, while both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu;
   import fpa_pkg::*;

   localparam int FRAC = 8;
   localparam int N_RANDOM = 800;
   localparam int LATENCY = 35 + FRAC;

   // One row of the directed table; has_exp marks a value typed in by hand.
   typedef struct {
      logic [3:0]  op;
      logic [31:0] a;
      logic [31:0] b;
      bit          has_exp;
      logic [31:0] value;
      logic        dz;
   } alu_row_type;

   // The outcome of one transaction.
   typedef struct {
      logic [31:0] value;
      logic        lt;
      logic        eq;
      logic        gt;
      logic        dz;
   } alu_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [3:0]         req_type;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_result_value;
   logic               rsp_is_less;
   logic               rsp_is_equal;
   logic               rsp_is_greater;
   logic               rsp_divide_by_zero;

   alu_result_type pending_results[$];
   int             error_count = 0;
   int             result_count = 0;
   bit             quiet_phase = 0;
   alu_row_type    directed[$];

   fixed_point_alu #(.FRAC_WIDTH(FRAC)) DUT (.*);

   // Clock generation.
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Safety limit on the run.
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Predict the outcome of one transaction.
   function automatic alu_result_type alu_predict(logic [3:0] op, logic signed [31:0] a,
                                                  logic signed [31:0] b);
      alu_result_type     r;
      logic signed [63:0] wide;
      logic [63:0]        num_mag;
      logic [63:0]        den_mag;
      logic [63:0]        quot;
      r.value = '0;
      r.dz = 0;
      r.lt = a < b;
      r.eq = a == b;
      r.gt = a > b;
      case (op)
         OP_ADD:      r.value = a + b;
         OP_SUB:      r.value = a - b;
         OP_MUL: begin
            wide = 64'(a) * 64'(b);
            wide = wide >>> FRAC;
            r.value = wide[31:0];
         end
         OP_DIV: begin
            if (b == 0) begin
               r.dz = 1;
            end else begin
               wide = 64'(a) <<< FRAC;
               num_mag = wide < 0 ? -wide : wide;
               den_mag = b < 0 ? -64'(b) : 64'(b);
               quot = num_mag / den_mag;
               if ((wide < 0) != (b < 0)) quot = -quot;
               r.value = quot[31:0];
            end
         end
         OP_INC:      r.value = a + 1;
         OP_DEC:      r.value = a - 1;
         OP_MIN:      r.value = (a < b) ? a : b;
         OP_MAX:      r.value = (a > b) ? a : b;
         OP_TO_INT:   r.value = a >>> FRAC;
         OP_FROM_INT: r.value = a << FRAC;
         default:     r.value = '0;
      endcase
      return r;
   endfunction

   // Present one transaction and wait until it is accepted.
   task automatic send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1;
      req_type      <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      pending_results.push_back(alu_predict(op, a, b));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Random stalls on the response side, in bursts.
   initial begin
      int burst;
      rsp_stall = 1;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            burst = $urandom_range(1, 8);
            repeat (burst) @(posedge clock);
         end
         rsp_stall <= 0;
         burst = $urandom_range(1, 12);
         repeat (burst - 1) @(posedge clock);
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      alu_result_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("Unexpected result, value %h", rsp_result_value);
            error_count++;
         end else begin
            exp = pending_results.pop_front();
            result_count++;
            if (rsp_result_value !== exp.value) begin
               $error("result_value: expected %h, actual %h", exp.value, rsp_result_value);
               error_count++;
            end
            if (rsp_is_less !== exp.lt) begin
               $error("is_less: expected %b, actual %b", exp.lt, rsp_is_less);
               error_count++;
            end
            if (rsp_is_equal !== exp.eq) begin
               $error("is_equal: expected %b, actual %b", exp.eq, rsp_is_equal);
               error_count++;
            end
            if (rsp_is_greater !== exp.gt) begin
               $error("is_greater: expected %b, actual %b", exp.gt, rsp_is_greater);
               error_count++;
            end
            if (rsp_divide_by_zero !== exp.dz) begin
               $error("divide_by_zero: expected %b, actual %b", exp.dz,
                      rsp_divide_by_zero);
               error_count++;
            end
         end
      end
   end

   // Random operand, biased towards extremes and small values.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($signed($urandom_range(0, 64)) - 32);
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   // Stimulus.
   initial begin
      logic [3:0]     op;
      logic [31:0]    a;
      logic [31:0]    b;
      int             wait_cycles;
      alu_result_type hand;

      reset = 1;
      req_valid = 0;
      req_type = OP_ADD;
      req_operand_a = '0;
      req_operand_b = '0;

      // Directed table: expected values given where they are obvious.
      directed = '{
         '{OP_ADD, 32'h7FFF_FFFF, 32'h1, 1, 32'h8000_0000, 0},
         '{OP_SUB, 32'h8000_0000, 32'h1, 1, 32'h7FFF_FFFF, 0},
         '{OP_MUL, 32'h0000_0200, 32'h0000_0300, 1, 32'h0000_0600, 0},
         '{OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, '0, 0},
         '{OP_MUL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, '0, 0},
         '{OP_DIV, 32'h0000_0600, 32'h0000_0200, 1, 32'h0000_0300, 0},
         '{OP_DIV, 32'h1234_5678, 32'h0, 1, 32'h0, 1},
         '{OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0, '0, 0},
         '{OP_DIV, 32'hFFFF_FFFF, 32'h0000_0003, 0, '0, 0},
         '{OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 0, '0, 0},
         '{OP_INC, 32'h7FFF_FFFF, 32'h5, 1, 32'h8000_0000, 0},
         '{OP_DEC, 32'h8000_0000, 32'h5, 1, 32'h7FFF_FFFF, 0},
         '{OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h0, 0},
         '{OP_CMP, 32'h0000_1234, 32'h0000_1234, 1, 32'h0, 0},
         '{OP_CMP, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h0, 0},
         '{OP_MIN, 32'hFFFF_FFFF, 32'h0000_0001, 1, 32'hFFFF_FFFF, 0},
         '{OP_MAX, 32'hFFFF_FFFF, 32'h0000_0001, 1, 32'h0000_0001, 0},
         '{OP_TO_INT, 32'hFFFF_FF00, 32'h0, 1, 32'hFFFF_FFFF, 0},
         '{OP_TO_INT, 32'h8000_0000, 32'h0, 1, 32'hFF80_0000, 0},
         '{OP_FROM_INT, 32'h0080_0001, 32'h0, 1, 32'h8000_0100, 0},
         '{4'd11, 32'h1, 32'h2, 1, 32'h0, 0},
         '{4'd15, 32'h5, 32'h2, 1, 32'h0, 0}
      };

      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Typed-in expectations are checked against the prediction too.
      foreach (directed[i]) begin
         if (directed[i].has_exp) begin
            hand = alu_predict(directed[i].op, directed[i].a, directed[i].b);
            if (hand.value !== directed[i].value || hand.dz !== directed[i].dz) begin
               $error("result_value: expected %h, actual %h (table row %0d)",
                      directed[i].value, hand.value, i);
               error_count++;
            end
         end
         send_request(directed[i].op, directed[i].a, directed[i].b);
      end

      // Random part; the last stretch runs with no idling at all.
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - 100) quiet_phase = 1;
         op = 4'($urandom_range(0, 15));
         if ($urandom_range(0, 7) != 0) op = 4'($urandom_range(0, 10));
         a = pick_operand();
         b = ($urandom_range(0, 5) == 0) ? a : pick_operand();
         send_request(op, a, b);
      end
      req_valid <= 0;

      // Drain the pipeline.
      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < 100_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 10) @(posedge clock);

      $display("Checked %0d results over all eleven operations and unknown codes,",
               result_count);
      $display("with operand extremes, divide by zero and random idling on both sides.");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/fpa_pkg.sv
sv/fpa_div.sv
sv/fixed_point_alu.sv
tb/sv/tb_fixed_point_alu.sv
